// ===== src/swmt_pkg.sv =====
package swmt_pkg;

  // Payload field widths
  localparam int unsigned KindW  = 1;
  localparam int unsigned ValueW = 32;
  localparam int unsigned BoundW = 20;
  localparam int unsigned MexW   = 10;

  // Stream packing, data padded to whole bytes
  localparam int unsigned InDataW  = 56;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 16;

  localparam int unsigned ValueLsb = 0;
  localparam int unsigned BoundLsb = ValueW;

  // Item kinds
  localparam logic [KindW-1:0] KIND_PUSH  = 1'b0;
  localparam logic [KindW-1:0] KIND_QUERY = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [MexW-1:0] mex;
  } swmt_res_t;

endpackage

// ===== src/swmt_ram.sv =====
module swmt_ram #(
  parameter int unsigned DATA_W = 20,
  parameter int unsigned ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned Depth = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [Depth];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/swmt_seq.sv =====
module swmt_seq #(
  parameter int unsigned VALUE_SLOTS   = 1024,
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [swmt_pkg::KindW-1:0]    kind_i,
  input  logic [swmt_pkg::ValueW-1:0]   value_i,
  input  logic [swmt_pkg::BoundW-1:0]   bound_i,
  output swmt_pkg::swmt_res_t           res_o,
  input  logic                          res_ready_i
);

  import swmt_pkg::*;

  localparam int unsigned Levels = $clog2(VALUE_SLOTS);
  localparam int unsigned AddrW  = Levels + 1;
  localparam int unsigned CmpW   = (POSITION_BITS > BoundW) ? POSITION_BITS : BoundW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD_RD,
    S_UPD_WR,
    S_QRY_RD,
    S_QRY_CMP,
    S_QRY_OUT
  } state_e;

  state_e                   state_q, state_d;
  logic [AddrW-1:0]         node_q, node_d;
  logic [AddrW-1:0]         clr_q, clr_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] cur_q, cur_d;
  logic [BoundW-1:0]        bound_q, bound_d;

  logic                     we;
  logic [AddrW-1:0]         waddr;
  logic [POSITION_BITS-1:0] wdata;
  logic [AddrW-1:0]         raddr;
  logic [POSITION_BITS-1:0] rdata;

  logic [Levels-1:0]        slot;
  logic [Levels-1:0]        leaf;
  logic [POSITION_BITS-1:0] pos_next;
  logic [POSITION_BITS-1:0] node_min;
  logic                     below;

  swmt_ram #(
    .DATA_W (POSITION_BITS),
    .ADDR_W (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Clamp oversized values into the top slot
  assign slot = (value_i > ValueW'(VALUE_SLOTS - 1)) ? Levels'(VALUE_SLOTS - 1)
                                                     : Levels'(value_i);
  assign pos_next = pos_q + POSITION_BITS'(1);
  assign node_min = (rdata < cur_q) ? rdata : cur_q;
  assign below    = CmpW'(rdata) < CmpW'(bound_q);

  // Leaves in the padding saturate at the top slot
  assign leaf = (node_q[Levels-1:0] > Levels'(VALUE_SLOTS - 1)) ? Levels'(VALUE_SLOTS - 1)
                                                                : node_q[Levels-1:0];

  assign in_ready_o = (state_q == S_IDLE);
  assign res_o.valid = (state_q == S_QRY_OUT);
  assign res_o.mex   = MexW'(leaf);

  always_comb begin
    state_d = state_q;
    node_d  = node_q;
    clr_d   = clr_q;
    pos_d   = pos_q;
    cur_d   = cur_q;
    bound_d = bound_q;
    we      = 1'b0;
    waddr   = clr_q;
    wdata   = '0;
    raddr   = node_q ^ AddrW'(1);

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + AddrW'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == KIND_QUERY) begin
            bound_d = bound_i;
            node_d  = AddrW'(1);
            state_d = S_QRY_RD;
          end else if (!(&pos_q)) begin
            // Write the leaf now, then walk up one level per S_UPD_RD/S_UPD_WR pass
            pos_d   = pos_next;
            cur_d   = pos_next;
            we      = 1'b1;
            waddr   = {1'b1, slot};
            wdata   = pos_next;
            node_d  = {1'b1, slot};
            state_d = S_UPD_RD;
          end
        end
      end
      S_UPD_RD: begin
        raddr   = node_q ^ AddrW'(1);
        state_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        we      = 1'b1;
        waddr   = node_q >> 1;
        wdata   = node_min;
        cur_d   = node_min;
        node_d  = node_q >> 1;
        state_d = ((node_q >> 1) == AddrW'(1)) ? S_IDLE : S_UPD_RD;
      end
      S_QRY_RD: begin
        raddr   = {node_q[AddrW-2:0], 1'b0};
        state_d = S_QRY_CMP;
      end
      S_QRY_CMP: begin
        // Go left if the left subtree holds a slot last seen before the bound
        node_d  = {node_q[AddrW-2:0], ~below};
        state_d = node_q[AddrW-2] ? S_QRY_OUT : S_QRY_RD;
      end
      S_QRY_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pos_q   <= '0;
      node_q  <= '0;
      cur_q   <= '0;
      bound_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pos_q   <= pos_d;
      node_q  <= node_d;
      cur_q   <= cur_d;
      bound_q <= bound_d;
    end
  end

endmodule

// ===== src/sliding_window_mex_tree.sv =====
// Channel  Dir  Fields (low bit up)
// s_axis   in   tuser: kind[0]; tdata: value[31:0], left_bound[51:32], zero[55:52]
// m_axis   out  tdata: mex[9:0], zero[15:10]
//
// One min tree in a single memory, one read and one write port, one node per access.
// Push: the leaf is written on acceptance, then each tree level upward takes a read and a write.
// Query: a read and a compare per level from the root down, then the result is handed off.
// After reset a clearing pass writes 2*2^ceil(log2(VALUE_SLOTS)) nodes, one a
// cycle; s_axis_tready stays low during it.
// A query result waits in an output register; a following item is taken while it waits.
module sliding_window_mex_tree #(
  parameter int unsigned VALUE_SLOTS   = 1024,
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [swmt_pkg::InDataW-1:0]   s_axis_tdata,  // value, left_bound
  input  logic [swmt_pkg::InUserW-1:0]   s_axis_tuser,  // kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [swmt_pkg::OutDataW-1:0]  m_axis_tdata   // mex
);

  import swmt_pkg::*;

  swmt_res_t       res;
  logic            res_ready;
  logic            out_valid_q, out_valid_d;
  logic [MexW-1:0] out_mex_q, out_mex_d;

  swmt_seq #(
    .VALUE_SLOTS   (VALUE_SLOTS),
    .POSITION_BITS (POSITION_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser[KindW-1:0]),
    .value_i     (s_axis_tdata[ValueLsb +: ValueW]),
    .bound_i     (s_axis_tdata[BoundLsb +: BoundW]),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_mex_d   = out_mex_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
      out_mex_d   = res.mex;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_mex_q <= out_mex_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_mex_q);

endmodule

// ===== dv/tb.sv =====
module tb;
  import swmt_pkg::*;

  localparam int unsigned SLOT_COUNT  = 1024;
  localparam int unsigned TOP_SLOT    = SLOT_COUNT - 1;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned RANDOM_GOAL = 120;
  localparam int unsigned RX_HOLD     = 400;
  localparam logic [BoundW-1:0] POS_FULL = '1;

  typedef struct {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
    logic [BoundW-1:0] bound;
    bit                drain;
    bit                calm;
  } stream_item_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;  // value[31:0], left_bound[51:32], zero[55:52]
  logic [InUserW-1:0]  s_axis_tuser = '0;  // kind[0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;       // mex[9:0], zero[15:10]

  sliding_window_mex_tree uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predicted block state: last position per value slot, and the position counter
  logic [BoundW-1:0] slot_last_pos [SLOT_COUNT];
  logic [BoundW-1:0] pos_count;

  stream_item_t      pending_q [$];
  logic [MexW-1:0]   mex_due_q [$];

  stream_item_t      head;
  logic              next_valid;
  logic              steady_phase = 1'b0;
  bit                calm_fill;
  int unsigned       plan_pos;
  int unsigned       fail_count;
  int unsigned       push_count;
  int unsigned       query_count;
  int unsigned       checked_count;
  int unsigned       saturated_count;
  int unsigned       rx_hold_left;
  bit                rx_hold_done;
  int unsigned       quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one accepted transaction to the predicted state
  task automatic apply_item(input stream_item_t it);
    logic [MexW-1:0] ans;
    int              s;
    if (it.kind == KIND_PUSH) begin
      push_count++;
      if (pos_count != POS_FULL) begin
        pos_count++;
        if (it.value > TOP_SLOT) slot_last_pos[TOP_SLOT] = pos_count;
        else slot_last_pos[it.value[MexW-1:0]] = pos_count;
      end
    end else begin
      query_count++;
      ans = MexW'(TOP_SLOT);
      for (s = TOP_SLOT - 1; s >= 0; s--) begin
        if (slot_last_pos[s] < it.bound) ans = MexW'(s);
      end
      mex_due_q.push_back(ans);
    end
  endtask

  task automatic add_item(input logic [KindW-1:0] kind, input logic [ValueW-1:0] value,
                          input logic [BoundW-1:0] bound, input bit drain);
    stream_item_t it;
    it.kind  = kind;
    it.value = value;
    it.bound = bound;
    it.drain = drain;
    it.calm  = calm_fill;
    pending_q.push_back(it);
    if (kind == KIND_PUSH) plan_pos++;
  endtask

  // Unused fields carry random content
  task automatic add_push(input logic [ValueW-1:0] value, input bit drain = 1'b0);
    add_item(KIND_PUSH, value, BoundW'($urandom()), drain);
  endtask

  task automatic add_query(input logic [BoundW-1:0] bound);
    add_item(KIND_QUERY, $urandom(), bound, 1'b0);
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      steady_phase  <= 1'b0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_item(pending_q[0]);
        void'(pending_q.pop_front());
        next_valid = 1'b0;
      end
      if (!next_valid && pending_q.size() != 0) begin
        head = pending_q[0];
        steady_phase <= head.calm;
        // Hold a drain-marked transaction until every answer is back
        if ((!head.drain || mex_due_q.size() == 0) &&
            (head.calm || $urandom_range(0, 99) >= 15)) begin
          next_valid = 1'b1;
          s_axis_tdata <= InDataW'({head.bound, head.value});
          s_axis_tuser <= head.kind;
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold_left = 0;
      rx_hold_done = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (mex_due_q.size() == 0) begin
          $error("unexpected result, mex %0d", m_axis_tdata[MexW-1:0]);
          fail_count++;
        end else begin
          if (m_axis_tdata[MexW-1:0] !== mex_due_q[0]) begin
            $error("mex: expected %0d, actual %0d", mex_due_q[0], m_axis_tdata[MexW-1:0]);
            fail_count++;
          end
          if (mex_due_q[0] == TOP_SLOT) saturated_count++;
          void'(mex_due_q.pop_front());
          checked_count++;
        end
        if (checked_count == 25 && !rx_hold_done) begin
          rx_hold_left = RX_HOLD;
          rx_hold_done = 1'b1;
        end
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady_phase || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned perm [TOP_SLOT];
    int unsigned random_items;
    int unsigned k;
    int unsigned maxv;
    int unsigned r;
    int unsigned j;
    int unsigned tmp;
    int unsigned sweep_start;
    int          b;

    quiet_cycles = 0;
    fail_count = 0;
    push_count = 0;
    query_count = 0;
    checked_count = 0;
    saturated_count = 0;
    pos_count = '0;
    foreach (slot_last_pos[i]) slot_last_pos[i] = '0;
    plan_pos = 0;
    calm_fill = 1'b0;

    // Empty tree: bound zero saturates, any other bound finds slot zero
    add_query('0);
    add_query(1);
    add_query('1);
    add_push(0);
    add_push(1);
    add_push(2);
    add_query(1);
    add_query(3);
    add_query(4);  // beyond the current position
    // Clamp into the top slot
    add_push(32'hFFFF_FFFF);
    add_push(TOP_SLOT);
    add_push(SLOT_COUNT);
    add_push(32'h8000_0000);
    add_query(1);
    add_query('0);
    add_query('1);
    add_push(3);
    add_query(1);
    add_query(6);
    add_push(32'h5555_5555);
    add_push(32'h2AAA_AAAA);
    add_query(20'hAAAAA);
    add_query(20'h55555);

    // Bursts of pushes mostly over a small value range, then queries mostly over recent windows
    random_items = 0;
    while (random_items < RANDOM_GOAL) begin
      calm_fill = (random_items >= 40 && random_items < 100);
      k = $urandom_range(1, 12);
      maxv = $urandom_range(2, 16);
      for (j = 0; j < k; j++) begin
        r = $urandom_range(0, 99);
        if (r < 5) add_push($urandom());
        else if (r < 10) add_push($urandom_range(1000, 1100));
        else add_push($urandom_range(0, maxv), random_items == 0 && j == 0);
      end
      random_items += k;
      for (j = $urandom_range(1, 3); j != 0; j--) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          add_query(BoundW'($urandom_range(0, 20'hFFFFF)));
        end else if (r < 8) begin
          add_query('0);
        end else begin
          b = int'(plan_pos) + 1 - int'($urandom_range(0, k + 8));
          if (b < 1) b = 1;
          add_query(BoundW'(b));
        end
        random_items++;
      end
    end
    calm_fill = 1'b0;

    // Full window: every slot below the top one in shuffled order
    for (j = 0; j < TOP_SLOT; j++) perm[j] = j;
    for (j = TOP_SLOT - 1; j > 0; j--) begin
      r = $urandom_range(0, j);
      tmp = perm[j];
      perm[j] = perm[r];
      perm[r] = tmp;
    end
    sweep_start = plan_pos + 1;
    for (j = 0; j < TOP_SLOT; j++) begin
      if ($urandom_range(0, 99) < 3) add_query(BoundW'($urandom_range(1, plan_pos + 1)));
      add_push(perm[j], j == 0);
    end
    add_query(BoundW'(sweep_start));
    for (j = 0; j < 30; j++) begin
      add_query(BoundW'(sweep_start + $urandom_range(1, TOP_SLOT - 1)));
    end
    add_query(BoundW'(sweep_start + TOP_SLOT - 1));
    add_query(BoundW'(sweep_start + TOP_SLOT));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (mex_due_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Covered %0d pushes and %0d queries, including a full-window sweep.",
             push_count, query_count);
    $display("Checked %0d answers, %0d of them saturated at the top slot.",
             checked_count, saturated_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/swmt_pkg.sv
src/swmt_ram.sv
src/swmt_seq.sv
src/sliding_window_mex_tree.sv
dv/tb.sv
